// ===== rtl/cluster_chain_table_defines.svh =====
// Assertion macros shared by the cluster chain table RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef CLUSTER_CHAIN_TABLE_DEFINES_SVH
`define CLUSTER_CHAIN_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCT_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cluster_chain_table: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CCT_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cluster_chain_table: next-cycle check failed");

`endif

// ===== rtl/cct_pkg.sv =====
// Shared types and constants of the cluster chain table.
// Used by the register file, the controller, the link memory and the top level.
package cct_pkg;

  // Default table size.
  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_GET    = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_ALLOC  = 3'd2;
  localparam logic [2:0] KIND_FREE   = 3'd3;
  localparam logic [2:0] KIND_LOCATE = 3'd4;

  // Link markers.
  localparam logic [31:0] LINK_FREE = 32'h0000_0000;
  localparam logic [31:0] LINK_END  = 32'hFFFF_FFFF;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned APB_AW = 5;
  localparam logic [2:0] REG_NUM_CLUSTERS  = 3'd0;
  localparam logic [2:0] REG_TABLE_START   = 3'd1;
  localparam logic [2:0] REG_SECTOR_SHIFT  = 3'd2;
  localparam logic [2:0] REG_HEAP_START    = 3'd3;
  localparam logic [2:0] REG_CLUSTER_SHIFT = 3'd4;

  // Sector size shift limits used for the flush sector.
  localparam logic [3:0] SECTOR_SHIFT_MIN = 4'd9;
  localparam logic [3:0] SECTOR_SHIFT_MAX = 4'd12;
  localparam logic [3:0] SECTOR_SHIFT_RST = 4'd9;

  // Configuration as seen by the controller.
  typedef struct packed {
    logic [11:0] num_clusters;
    logic [31:0] table_start_sector;
    logic [3:0]  sector_size_shift;
    logic [31:0] heap_start_sector;
    logic [4:0]  cluster_size_shift;
  } cfg_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic clearing;
    logic scanning;
  } stat_t;

endpackage

// ===== rtl/cct_if.sv =====
// Valid/ready channels of the cluster chain table: requests and results.
// Depends on nothing but the field widths fixed by the block.
interface cct_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] cluster;
  logic [31:0] link_value;

  modport source(output valid, kind, cluster, link_value, input ready);
  modport sink(input valid, kind, cluster, link_value, output ready);
endinterface

interface cct_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        status;
  logic        flush_valid;
  logic [32:0] flush_sector;

  modport source(output valid, value, status, flush_valid, flush_sector, input ready);
  modport sink(input valid, value, status, flush_valid, flush_sector, output ready);
endinterface

// ===== rtl/cct_regs.sv =====
// APB-style configuration registers of the cluster chain table.
// Depends on cct_pkg for the register indexes and the cfg_t type.
module cct_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cct_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cct_pkg::cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_strobe;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[cct_pkg::APB_AW-1:2];
  assign wr_strobe = psel && penable && pwrite && pready;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_clusters       <= 12'd0;
      cfg.table_start_sector <= 32'd0;
      cfg.sector_size_shift  <= cct_pkg::SECTOR_SHIFT_RST;
      cfg.heap_start_sector  <= 32'd0;
      cfg.cluster_size_shift <= 5'd0;
    end else if (wr_strobe) begin
      case (reg_idx)
        cct_pkg::REG_NUM_CLUSTERS:  cfg.num_clusters       <= pwdata[11:0];
        cct_pkg::REG_TABLE_START:   cfg.table_start_sector <= pwdata;
        cct_pkg::REG_SECTOR_SHIFT:  cfg.sector_size_shift  <= pwdata[3:0];
        cct_pkg::REG_HEAP_START:    cfg.heap_start_sector  <= pwdata;
        cct_pkg::REG_CLUSTER_SHIFT: cfg.cluster_size_shift <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      cct_pkg::REG_NUM_CLUSTERS:  prdata = 32'(cfg.num_clusters);
      cct_pkg::REG_TABLE_START:   prdata = cfg.table_start_sector;
      cct_pkg::REG_SECTOR_SHIFT:  prdata = 32'(cfg.sector_size_shift);
      cct_pkg::REG_HEAP_START:    prdata = cfg.heap_start_sector;
      cct_pkg::REG_CLUSTER_SHIFT: prdata = 32'(cfg.cluster_size_shift);
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/cct_link_mem.sv =====
// Link table storage: one write port and one read port with registered data.
// Depends on cct_pkg for the default depth; the top level sets the depth.
module cct_link_mem #(
  parameter int unsigned TABLE_DEPTH = cct_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] links [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      links[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= links[rd_addr];
    end
  end

endmodule

// ===== rtl/cct_ctrl.sv =====
// Operation sequencer of the cluster chain table: clearing pass, single
// accesses, the free-entry scan and the result register. Depends on cct_pkg.
module cct_ctrl #(
  parameter int unsigned TABLE_DEPTH = cct_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = AW + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  cct_pkg::cfg_t   cfg,
  cct_req_if.sink         req,
  cct_rsp_if.source       rsp,
  output logic            mem_wr_en,
  output logic [AW-1:0]   mem_wr_addr,
  output logic [31:0]     mem_wr_data,
  output logic            mem_rd_en,
  output logic [AW-1:0]   mem_rd_addr,
  input  logic [31:0]     mem_rd_data,
  output cct_pkg::stat_t  stat
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] clr_idx;
  logic [2:0]    op_kind;
  logic [31:0]   op_cluster;
  logic          op_in_range;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] chk_idx;
  logic          pend;
  logic [31:0]   hold_value;

  logic          accept;
  logic          out_free;
  logic          rsp_load;
  logic [32:0]   lim_cnt;
  logic [32:0]   lim_full;
  logic [CW-1:0] lim_idx;
  logic          req_in_range;
  logic          req_is_write;
  logic          scan_issue;
  logic          scan_hit;
  logic          scan_empty;
  logic [3:0]    sec_shift;
  logic [32:0]   flush_sum;
  logic [31:0]   res_value;
  logic          res_status;
  logic          res_fvalid;
  logic [32:0]   res_fsector;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = (state inside {ST_EXEC, ST_DONE}) && out_free;

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.scanning = (state == ST_SCAN);

  // One past the last valid cluster, cut off at the table end.
  assign lim_cnt  = 33'(cfg.num_clusters) + 33'd2;
  assign lim_full = (lim_cnt > 33'(TABLE_DEPTH)) ? 33'(TABLE_DEPTH) : lim_cnt;
  assign lim_idx  = lim_full[CW-1:0];

  assign req_in_range = (req.cluster >= 32'd2) && ({1'b0, req.cluster} < lim_full);
  assign req_is_write = (req.kind == cct_pkg::KIND_SET) || (req.kind == cct_pkg::KIND_FREE);

  // Scan pipeline: a read issued last cycle is checked this cycle.
  assign scan_issue = (rd_idx < lim_idx);
  assign scan_hit   = pend && (mem_rd_data == cct_pkg::LINK_FREE);
  assign scan_empty = !pend && !scan_issue;

  // Table port selection by state.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = req.cluster[AW-1:0];
    mem_wr_data = cct_pkg::LINK_FREE;
    mem_rd_en   = 1'b0;
    mem_rd_addr = req.cluster[AW-1:0];
    case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx;
      end
      ST_IDLE: begin
        mem_wr_en   = accept && req_is_write && req_in_range;
        mem_wr_data = (req.kind == cct_pkg::KIND_SET) ? req.link_value : cct_pkg::LINK_FREE;
        mem_rd_en   = accept && (req.kind == cct_pkg::KIND_GET);
      end
      ST_SCAN: begin
        mem_wr_en   = scan_hit;
        mem_wr_addr = chk_idx;
        mem_wr_data = cct_pkg::LINK_END;
        mem_rd_en   = scan_issue && !scan_hit;
        mem_rd_addr = rd_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  // Flush sector: links per sector is bytes per sector over four.
  always_comb begin
    if (cfg.sector_size_shift < cct_pkg::SECTOR_SHIFT_MIN) begin
      sec_shift = cct_pkg::SECTOR_SHIFT_MIN;
    end else if (cfg.sector_size_shift > cct_pkg::SECTOR_SHIFT_MAX) begin
      sec_shift = cct_pkg::SECTOR_SHIFT_MAX;
    end else begin
      sec_shift = cfg.sector_size_shift;
    end
  end
  assign flush_sum = 33'(cfg.table_start_sector) + 33'(op_cluster >> (sec_shift - 4'd2));

  // Result of a single-access operation.
  always_comb begin
    res_value   = 32'd0;
    res_status  = 1'b0;
    res_fvalid  = 1'b0;
    res_fsector = 33'd0;
    case (op_kind)
      cct_pkg::KIND_GET: begin
        res_value = op_in_range ? mem_rd_data : cct_pkg::LINK_END;
      end
      cct_pkg::KIND_SET, cct_pkg::KIND_FREE: begin
        if (op_in_range) begin
          res_fvalid  = 1'b1;
          res_fsector = flush_sum;
        end else begin
          res_status = 1'b1;
        end
      end
      cct_pkg::KIND_LOCATE: begin
        if (op_cluster >= 32'd2) begin
          res_value = cfg.heap_start_sector + ((op_cluster - 32'd2) << cfg.cluster_size_shift);
        end
      end
      default: ;
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_kind     <= req.kind;
            op_cluster  <= req.cluster;
            op_in_range <= req_in_range;
            if (req.kind == cct_pkg::KIND_ALLOC) begin
              rd_idx <= CW'(2);
              pend   <= 1'b0;
              state  <= ST_SCAN;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            rsp.value        <= res_value;
            rsp.status       <= res_status;
            rsp.flush_valid  <= res_fvalid;
            rsp.flush_sector <= res_fsector;
            state            <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            hold_value <= 32'(chk_idx);
            state      <= ST_DONE;
          end else if (scan_empty) begin
            hold_value <= 32'd0;
            state      <= ST_DONE;
          end else begin
            pend <= scan_issue;
            if (scan_issue) begin
              chk_idx <= rd_idx[AW-1:0];
              rd_idx  <= rd_idx + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp.value        <= hold_value;
            rsp.status       <= 1'b0;
            rsp.flush_valid  <= 1'b0;
            rsp.flush_sector <= 33'd0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cluster_chain_table.sv =====
// Top level of the cluster chain table: registers, controller and link memory.
// Depends on cct_pkg, the channel interfaces and the assertion macro header.
//
//   channel   dir  handshake              carries
//   req       in   valid/ready            kind, cluster, link_value
//   rsp       out  valid/ready            value, status, flush_valid, flush_sector
//   apb       in   psel/penable, pready=1 configuration writes and reads
//
// Get, set, free and locate are accepted with the table access; the result is
// then formed and registered once the output register is free. Allocate reads
// the entries in range one at a time through the single table read port up to
// the free one, marks it as a chain end and returns its number; with nothing
// free it returns zero. After reset a clearing pass writes free to every entry
// while req.ready stays low. A stalled result holds in the output register, and
// one more item may be taken and wait for it before req.ready drops.
`include "cluster_chain_table_defines.svh"

module cluster_chain_table #(
  parameter int unsigned TABLE_DEPTH = cct_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  cct_req_if.sink                     req,
  cct_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cct_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  cct_pkg::cfg_t  cfg;
  cct_pkg::stat_t stat;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [31:0]    mem_wr_data;
  logic           mem_rd_en;
  logic [AW-1:0]  mem_rd_addr;
  logic [31:0]    mem_rd_data;

  // Configuration registers.
  cct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Operation sequencer.
  cct_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (req),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .stat        (stat)
  );

  // Link table.
  cct_link_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // No item is taken during the clearing pass or a scan.
  `CCT_ASSERT_IMPL(a_no_accept_busy, clk, rst, stat.clearing || stat.scanning, !req.ready)
  // One item at a time: an accept is never followed by another in the next cycle.
  `CCT_ASSERT_NEXT(a_one_item, clk, rst, req.valid && req.ready, !req.ready)
  // Outside the clearing pass the table is never written below cluster two.
  `CCT_ASSERT_IMPL(a_wr_range, clk, rst, mem_wr_en && !stat.clearing, mem_wr_addr >= AW'(2))
  // A flush request never comes with an out-of-range status.
  `CCT_ASSERT_IMPL(a_flush_status, clk, rst, rsp.valid && rsp.flush_valid, !rsp.status)

endmodule
